>>> rtl/htvl_pkg.sv
`timescale 1ns / 1ps

package htvl_pkg;

  localparam int TOTAL_W  = 48;
  localparam int JB_W     = 32;
  localparam int SHIFT_W  = 4;
  localparam int IDX_W    = 6;
  localparam int LCNT_W   = 7;
  localparam int ST_W     = 2;
  localparam int ACT_W    = 4;
  localparam int LOW_W    = TOTAL_W + 1;
  localparam int SUM_W    = TOTAL_W + 1;
  localparam int USED_W   = TOTAL_W + 2;

  localparam int MAX_LEVELS_DEF = 16;

  localparam logic [SHIFT_W-1:0] SHIFT_RST      = 4'd7;
  localparam logic [TOTAL_W-1:0] MIN_BLOCKS     = 48'd6;
  localparam logic [LCNT_W-1:0]  LEVEL_SLOTS_M1 = 7'd63;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_SMALL = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd2;
  localparam logic [ST_W-1:0] ST_DEEP  = 2'd3;

  // datapath actions, one per microcode word
  localparam logic [ACT_W-1:0] A_LOAD  = 4'd0;
  localparam logic [ACT_W-1:0] A_CHK   = 4'd1;
  localparam logic [ACT_W-1:0] A_TEST  = 4'd2;
  localparam logic [ACT_W-1:0] A_MID   = 4'd3;
  localparam logic [ACT_W-1:0] A_TINIT = 4'd4;
  localparam logic [ACT_W-1:0] A_TSTEP = 4'd5;
  localparam logic [ACT_W-1:0] A_TTOP  = 4'd6;
  localparam logic [ACT_W-1:0] A_USED  = 4'd7;
  localparam logic [ACT_W-1:0] A_PAD   = 4'd8;
  localparam logic [ACT_W-1:0] A_UPD   = 4'd9;
  localparam logic [ACT_W-1:0] A_DONE  = 4'd10;
  localparam logic [ACT_W-1:0] A_EMIT  = 4'd11;
  localparam logic [ACT_W-1:0] A_ERR   = 4'd12;
  localparam logic [ACT_W-1:0] A_NOP   = 4'd13;

  typedef struct packed {
    logic no_in;
    logic few;
    logic loop_end;
    logic mid_zero;
    logic tree_more;
    logic ne;
    logic bad;
    logic out_busy;
    logic last_lvl;
  } htvl_flags_t;

  function automatic logic [TOTAL_W-1:0] ceil_shift(input logic [TOTAL_W-1:0] x,
                                                    input logic [SHIFT_W-1:0] s);
    logic [TOTAL_W-1:0] m;
    m = (TOTAL_W'(1) << s) - TOTAL_W'(1);
    return (x >> s) + TOTAL_W'((x & m) != '0);
  endfunction

endpackage

>>> rtl/hash_tree_volume_layout.sv
`timescale 1ns / 1ps
// Each input transaction runs P binary-search probes (at most 49), each walking
//   L tree levels through the shared ceil-shift unit, and then issues R results
//   (one per cycle when the output is not stalled).
// Throughput: one input transaction in flight; the next is taken once the last
//   result has been loaded into the output register.
// Reset (rst_n, synchronous, active low): sequencer to idle, output invalid,
//   fanout_shift back to 7.

module hash_tree_volume_layout import htvl_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [SHIFT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TOTAL_W-1:0] in_total_blocks,
  input  logic [JB_W-1:0]    in_journal_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   out_level_index,
  output logic [TOTAL_W-1:0] out_level_blocks,
  output logic [TOTAL_W-1:0] out_data_count,
  output logic [TOTAL_W-1:0] out_hash_count,
  output logic [JB_W-1:0]    out_journal_used,
  output logic [TOTAL_W-1:0] out_pad_count,
  output logic [LCNT_W-1:0]  out_level_count,
  output logic [ST_W-1:0]    out_status,
  output logic               out_last
);

  logic [ACT_W-1:0] act;
  htvl_flags_t      flags;

  assign in_stall = !rst_n || (act != A_LOAD);

  htvl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act)
  );

  htvl_datapath #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .act              (act),
    .flags            (flags),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_total_blocks  (in_total_blocks),
    .in_journal_count (in_journal_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_index  (out_level_index),
    .out_level_blocks (out_level_blocks),
    .out_data_count   (out_data_count),
    .out_hash_count   (out_hash_count),
    .out_journal_used (out_journal_used),
    .out_pad_count    (out_pad_count),
    .out_level_count  (out_level_count),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

>>> rtl/htvl_seq.sv
`timescale 1ns / 1ps

module htvl_seq import htvl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  htvl_flags_t      flags,
  output logic [ACT_W-1:0] act
);

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_CHK   = 4'd1;
  localparam logic [PC_W-1:0] S_TEST  = 4'd2;
  localparam logic [PC_W-1:0] S_MID   = 4'd3;
  localparam logic [PC_W-1:0] S_TINIT = 4'd4;
  localparam logic [PC_W-1:0] S_TSTEP = 4'd5;
  localparam logic [PC_W-1:0] S_TTOP  = 4'd6;
  localparam logic [PC_W-1:0] S_USED  = 4'd7;
  localparam logic [PC_W-1:0] S_PAD   = 4'd8;
  localparam logic [PC_W-1:0] S_UPD   = 4'd9;
  localparam logic [PC_W-1:0] S_DONE  = 4'd10;
  localparam logic [PC_W-1:0] S_EMIT  = 4'd11;
  localparam logic [PC_W-1:0] S_ERR   = 4'd12;

  localparam logic [3:0] C_ALWAYS    = 4'd0;
  localparam logic [3:0] C_NO_IN     = 4'd1;
  localparam logic [3:0] C_SMALL     = 4'd2;
  localparam logic [3:0] C_LOOP_END  = 4'd3;
  localparam logic [3:0] C_MID_ZERO  = 4'd4;
  localparam logic [3:0] C_TREE_MORE = 4'd5;
  localparam logic [3:0] C_NE        = 4'd6;
  localparam logic [3:0] C_BAD       = 4'd7;
  localparam logic [3:0] C_OUT_BUSY  = 4'd8;
  localparam logic [3:0] C_EMIT_MORE = 4'd9;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [3:0]       cond;
    logic [PC_W-1:0]  tgt_t;
    logic [PC_W-1:0]  tgt_f;
  } ucw_t;

  // control store: action, jump condition, target when true, target when false
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      S_IDLE:  w = '{A_LOAD,  C_NO_IN,     S_IDLE,  S_CHK};
      S_CHK:   w = '{A_CHK,   C_SMALL,     S_ERR,   S_TEST};
      S_TEST:  w = '{A_TEST,  C_LOOP_END,  S_DONE,  S_MID};
      S_MID:   w = '{A_MID,   C_ALWAYS,    S_TINIT, S_TINIT};
      S_TINIT: w = '{A_TINIT, C_MID_ZERO,  S_DONE,  S_TSTEP};
      S_TSTEP: w = '{A_TSTEP, C_TREE_MORE, S_TSTEP, S_TTOP};
      S_TTOP:  w = '{A_TTOP,  C_ALWAYS,    S_USED,  S_USED};
      S_USED:  w = '{A_USED,  C_ALWAYS,    S_PAD,   S_PAD};
      S_PAD:   w = '{A_PAD,   C_ALWAYS,    S_UPD,   S_UPD};
      S_UPD:   w = '{A_UPD,   C_NE,        S_TEST,  S_DONE};
      S_DONE:  w = '{A_DONE,  C_BAD,       S_ERR,   S_EMIT};
      S_EMIT:  w = '{A_EMIT,  C_EMIT_MORE, S_EMIT,  S_IDLE};
      S_ERR:   w = '{A_ERR,   C_OUT_BUSY,  S_ERR,   S_IDLE};
      default: w = '{A_NOP,   C_ALWAYS,    S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucw_t            uw;
  logic            cond_hit;

  assign uw  = ucode(pc_r);
  assign act = uw.act;

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_NO_IN:     cond_hit = flags.no_in;
      C_SMALL:     cond_hit = flags.few;
      C_LOOP_END:  cond_hit = flags.loop_end;
      C_MID_ZERO:  cond_hit = flags.mid_zero;
      C_TREE_MORE: cond_hit = flags.tree_more;
      C_NE:        cond_hit = flags.ne;
      C_BAD:       cond_hit = flags.bad;
      C_OUT_BUSY:  cond_hit = flags.out_busy;
      C_EMIT_MORE: cond_hit = flags.out_busy || !flags.last_lvl;
      default:     cond_hit = 1'b1;
    endcase
    pc_nxt = cond_hit ? uw.tgt_t : uw.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/htvl_datapath.sv
`timescale 1ns / 1ps

module htvl_datapath import htvl_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ACT_W-1:0]   act,
  output htvl_flags_t        flags,
  input  logic               cfg_wr_en,
  input  logic [SHIFT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic [TOTAL_W-1:0] in_total_blocks,
  input  logic [JB_W-1:0]    in_journal_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   out_level_index,
  output logic [TOTAL_W-1:0] out_level_blocks,
  output logic [TOTAL_W-1:0] out_data_count,
  output logic [TOTAL_W-1:0] out_hash_count,
  output logic [JB_W-1:0]    out_journal_used,
  output logic [TOTAL_W-1:0] out_pad_count,
  output logic [LCNT_W-1:0]  out_level_count,
  output logic [ST_W-1:0]    out_status,
  output logic               out_last
);

  logic [SHIFT_W-1:0] fanout_shift_r, fanout_shift_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [JB_W-1:0]    jb_r, jb_nxt;
  logic [SHIFT_W-1:0] s_r, s_nxt;
  logic [TOTAL_W-1:0] avail_r, avail_nxt;
  logic [LOW_W-1:0]   low_r, low_nxt;
  logic [TOTAL_W-1:0] high_r, high_nxt;
  logic [TOTAL_W-1:0] d_r, d_nxt;
  logic [TOTAL_W-1:0] mid_r, mid_nxt;
  logic [TOTAL_W-1:0] i_r, i_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [LCNT_W-1:0]  lev_r, lev_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic [TOTAL_W-1:0] pad_r, pad_nxt;
  logic               gt_r, gt_nxt;
  logic [TOTAL_W-1:0] best_db_r, best_db_nxt;
  logic [TOTAL_W-1:0] best_hb_r, best_hb_nxt;
  logic [TOTAL_W-1:0] best_pad_r, best_pad_nxt;
  logic [LCNT_W-1:0]  best_lev_r, best_lev_nxt;
  logic [ST_W-1:0]    err_r, err_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;

  logic [IDX_W-1:0]   o_idx_r, o_idx_nxt;
  logic [TOTAL_W-1:0] o_lvl_r, o_lvl_nxt;
  logic [TOTAL_W-1:0] o_db_r, o_db_nxt;
  logic [TOTAL_W-1:0] o_hb_r, o_hb_nxt;
  logic [JB_W-1:0]    o_jb_r, o_jb_nxt;
  logic [TOTAL_W-1:0] o_pad_r, o_pad_nxt;
  logic [LCNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic [ST_W-1:0]    o_st_r, o_st_nxt;
  logic               o_last_r, o_last_nxt;

  logic [TOTAL_W-1:0] shf_in, shf;
  logic [USED_W:0]    pad_diff;
  logic               out_busy, nofit, too_deep, last_lvl, out_load;

  // one shared ceil-divide-by-fanout unit
  always_comb begin
    unique case (act)
      A_TINIT: shf_in = mid_r;
      A_DONE:  shf_in = best_db_r;
      default: shf_in = i_r;
    endcase
  end
  assign shf = ceil_shift(shf_in, s_r);

  assign pad_diff = {1'b0, 2'b00, avail_r} - {1'b0, used_r};
  assign out_busy = out_valid_r && out_stall;
  assign nofit    = best_pad_r == avail_r;
  assign too_deep = best_lev_r > LCNT_W'(MAX_LEVELS);
  assign last_lvl = ({1'b0, k_r} + LCNT_W'(1)) == best_lev_r;
  assign out_load = ((act == A_EMIT) || (act == A_ERR)) && !out_busy;

  always_comb begin
    flags.no_in     = !in_valid;
    flags.few       = total_r < MIN_BLOCKS;
    flags.loop_end  = ({1'b0, high_r} < low_r) || (high_r == '0);
    flags.mid_zero  = mid_r == '0;
    flags.tree_more = (i_r != TOTAL_W'(1)) && (lev_r < LEVEL_SLOTS_M1);
    flags.ne        = gt_r || (pad_r != '0);
    flags.bad       = nofit || too_deep;
    flags.out_busy  = out_busy;
    flags.last_lvl  = last_lvl;
  end

  always_comb begin
    fanout_shift_nxt = cfg_wr_en ? cfg_wr_data : fanout_shift_r;
    out_valid_nxt    = out_load ? 1'b1 : out_busy;

    total_nxt    = total_r;
    jb_nxt       = jb_r;
    s_nxt        = s_r;
    avail_nxt    = avail_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    d_nxt        = d_r;
    mid_nxt      = mid_r;
    i_nxt        = i_r;
    sum_nxt      = sum_r;
    lev_nxt      = lev_r;
    used_nxt     = used_r;
    pad_nxt      = pad_r;
    gt_nxt       = gt_r;
    best_db_nxt  = best_db_r;
    best_hb_nxt  = best_hb_r;
    best_pad_nxt = best_pad_r;
    best_lev_nxt = best_lev_r;
    err_nxt      = err_r;
    k_nxt        = k_r;

    o_idx_nxt  = o_idx_r;
    o_lvl_nxt  = o_lvl_r;
    o_db_nxt   = o_db_r;
    o_hb_nxt   = o_hb_r;
    o_jb_nxt   = o_jb_r;
    o_pad_nxt  = o_pad_r;
    o_cnt_nxt  = o_cnt_r;
    o_st_nxt   = o_st_r;
    o_last_nxt = o_last_r;

    unique case (act)
      A_LOAD: begin
        if (in_valid) begin
          total_nxt = in_total_blocks;
          jb_nxt    = in_journal_count;
          // a shift of zero would never shrink the tree
          s_nxt     = (fanout_shift_r == '0) ? SHIFT_W'(1) : fanout_shift_r;
        end
      end
      A_CHK: begin
        avail_nxt    = total_r - TOTAL_W'(1);
        high_nxt     = total_r - TOTAL_W'(1);
        best_pad_nxt = total_r - TOTAL_W'(1);
        low_nxt      = '0;
        err_nxt      = ST_SMALL;
      end
      A_TEST: begin
        d_nxt = high_r - low_r[TOTAL_W-1:0];
      end
      A_MID: begin
        // low <= high here, so low fits the narrower width
        mid_nxt = low_r[TOTAL_W-1:0] + (d_r >> 1) + TOTAL_W'(d_r[0]);
      end
      A_TINIT: begin
        i_nxt   = shf;
        sum_nxt = '0;
        lev_nxt = '0;
      end
      A_TSTEP: begin
        if (flags.tree_more) begin
          sum_nxt = sum_r + SUM_W'(i_r);
          lev_nxt = lev_r + LCNT_W'(1);
          i_nxt   = shf;
        end
      end
      A_TTOP: begin
        sum_nxt  = sum_r + SUM_W'(1);
        lev_nxt  = lev_r + LCNT_W'(1);
        used_nxt = USED_W'(mid_r) + USED_W'(jb_r);
      end
      A_USED: begin
        used_nxt = used_r + USED_W'(sum_r);
      end
      A_PAD: begin
        gt_nxt  = pad_diff[USED_W];
        pad_nxt = pad_diff[TOTAL_W-1:0];
      end
      A_UPD: begin
        if (!gt_r && (pad_r < best_pad_r)) begin
          best_db_nxt  = mid_r;
          best_hb_nxt  = sum_r[TOTAL_W-1:0];
          best_pad_nxt = pad_r;
          best_lev_nxt = lev_r;
        end
        if (gt_r) begin
          high_nxt = mid_r - TOTAL_W'(1);
        end else if (pad_r != '0) begin
          low_nxt = LOW_W'(mid_r) + LOW_W'(1);
        end
      end
      A_DONE: begin
        err_nxt = nofit ? ST_NOFIT : ST_DEEP;
        k_nxt   = '0;
        i_nxt   = shf;
      end
      A_EMIT: begin
        if (!out_busy) begin
          o_idx_nxt  = k_r;
          o_lvl_nxt  = i_r;
          o_db_nxt   = best_db_r;
          o_hb_nxt   = best_hb_r;
          o_jb_nxt   = jb_r;
          o_pad_nxt  = best_pad_r;
          o_cnt_nxt  = best_lev_r;
          o_st_nxt   = ST_OK;
          o_last_nxt = last_lvl;
          k_nxt      = k_r + IDX_W'(1);
          i_nxt      = shf;
        end
      end
      A_ERR: begin
        if (!out_busy) begin
          o_idx_nxt  = '0;
          o_lvl_nxt  = '0;
          o_db_nxt   = '0;
          o_hb_nxt   = '0;
          o_jb_nxt   = '0;
          o_pad_nxt  = '0;
          o_cnt_nxt  = '0;
          o_st_nxt   = err_r;
          o_last_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fanout_shift_r <= SHIFT_RST;
      out_valid_r    <= 1'b0;
    end else begin
      fanout_shift_r <= fanout_shift_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    jb_r       <= jb_nxt;
    s_r        <= s_nxt;
    avail_r    <= avail_nxt;
    low_r      <= low_nxt;
    high_r     <= high_nxt;
    d_r        <= d_nxt;
    mid_r      <= mid_nxt;
    i_r        <= i_nxt;
    sum_r      <= sum_nxt;
    lev_r      <= lev_nxt;
    used_r     <= used_nxt;
    pad_r      <= pad_nxt;
    gt_r       <= gt_nxt;
    best_db_r  <= best_db_nxt;
    best_hb_r  <= best_hb_nxt;
    best_pad_r <= best_pad_nxt;
    best_lev_r <= best_lev_nxt;
    err_r      <= err_nxt;
    k_r        <= k_nxt;
    o_idx_r    <= o_idx_nxt;
    o_lvl_r    <= o_lvl_nxt;
    o_db_r     <= o_db_nxt;
    o_hb_r     <= o_hb_nxt;
    o_jb_r     <= o_jb_nxt;
    o_pad_r    <= o_pad_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_st_r     <= o_st_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_level_index  = o_idx_r;
  assign out_level_blocks = o_lvl_r;
  assign out_data_count   = o_db_r;
  assign out_hash_count   = o_hb_r;
  assign out_journal_used = o_jb_r;
  assign out_pad_count    = o_pad_r;
  assign out_level_count  = o_cnt_r;
  assign out_status       = o_st_r;
  assign out_last         = o_last_r;

endmodule

>>> rtl/htvl_checker.sv
`timescale 1ns / 1ps

module htvl_checker import htvl_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [IDX_W-1:0]   out_level_index,
  input logic [TOTAL_W-1:0] out_data_count,
  input logic [LCNT_W-1:0]  out_level_count,
  input logic [ST_W-1:0]    out_status,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_level_count == '0) && (out_data_count == '0))
    else $error("error result carries counts");

  a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |->
      (out_last == (({1'b0, out_level_index} + LCNT_W'(1)) == out_level_count)))
    else $error("last mark does not match top level");

endmodule

bind hash_tree_volume_layout htvl_checker u_htvl_checker (.*);

>>> verif/tb_hash_tree_volume_layout.sv
`timescale 1ns / 1ps

module tb_hash_tree_volume_layout;
  import htvl_pkg::*;

  localparam int MAX_LEVELS = MAX_LEVELS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 4000;
  localparam int RAND_PER_PHASE = 27;

  typedef struct {
    logic [IDX_W-1:0]   lvl;
    logic [TOTAL_W-1:0] lvl_blocks;
    logic [TOTAL_W-1:0] data;
    logic [TOTAL_W-1:0] hash;
    logic [JB_W-1:0]    jb;
    logic [TOTAL_W-1:0] pad;
    logic [LCNT_W-1:0]  lcnt;
    logic [ST_W-1:0]    st;
    logic               last;
  } layout_rec_t;

  typedef struct {
    logic [SHIFT_W-1:0] shift;
    logic [TOTAL_W-1:0] total;
    logic [JB_W-1:0]    jb;
    logic               typed;  // expected status typed in, no prediction
    logic [ST_W-1:0]    st;
  } layout_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [SHIFT_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [TOTAL_W-1:0] in_total_blocks = '0;
  logic [JB_W-1:0]    in_journal_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [IDX_W-1:0]   out_level_index;
  logic [TOTAL_W-1:0] out_level_blocks;
  logic [TOTAL_W-1:0] out_data_count;
  logic [TOTAL_W-1:0] out_hash_count;
  logic [JB_W-1:0]    out_journal_used;
  logic [TOTAL_W-1:0] out_pad_count;
  logic [LCNT_W-1:0]  out_level_count;
  logic [ST_W-1:0]    out_status;
  logic               out_last;

  layout_rec_t layout_q[$];
  layout_req_t dir_rows[$];
  logic [SHIFT_W-1:0] shift_cfg = SHIFT_RST;
  int err_count = 0;
  int items_in = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  hash_tree_volume_layout #(.MAX_LEVELS(MAX_LEVELS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_total_blocks  (in_total_blocks),
    .in_journal_count (in_journal_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_index  (out_level_index),
    .out_level_blocks (out_level_blocks),
    .out_data_count   (out_data_count),
    .out_hash_count   (out_hash_count),
    .out_journal_used (out_journal_used),
    .out_pad_count    (out_pad_count),
    .out_level_count  (out_level_count),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned div_up(input longint unsigned x, input int s);
    longint unsigned m;
    m = (64'd1 << s) - 64'd1;
    return (x >> s) + (((x & m) != 0) ? 64'd1 : 64'd0);
  endfunction

  function automatic void push_fault(input logic [ST_W-1:0] st);
    layout_rec_t r;
    r.lvl = '0;
    r.lvl_blocks = '0;
    r.data = '0;
    r.hash = '0;
    r.jb = '0;
    r.pad = '0;
    r.lcnt = '0;
    r.st = st;
    r.last = 1'b1;
    layout_q.push_back(r);
  endfunction

  // Binary search for the data count giving the least padding, then one
  // record per tree level, or a single fault record on any error.
  function automatic void plan_layout(input logic [TOTAL_W-1:0] total,
                                      input logic [JB_W-1:0] jb);
    int s;
    int n;
    int best_lev;
    longint unsigned avail, lo, hi, mid, x, hb, used;
    longint unsigned best_db, best_hb, best_pad;
    longint unsigned per[64];
    longint unsigned best_per[64];
    layout_rec_t r;
    s = (shift_cfg == 0) ? 1 : int'(shift_cfg);
    if (total < MIN_BLOCKS) begin
      push_fault(ST_SMALL);
      return;
    end
    avail = total - 1;
    best_pad = avail;
    best_db = 0;
    best_hb = 0;
    best_lev = 0;
    lo = 0;
    hi = avail;
    for (int k = 0; k < 64; k++) begin
      per[k] = 0;
      best_per[k] = 0;
    end
    while (hi >= lo && hi != 0) begin
      mid = lo + div_up(hi - lo, 1);
      if (mid == 0) break;  // zero data count: abandon the search
      x = div_up(mid, s);
      n = 0;
      hb = 0;
      while (x != 1 && n < int'(LEVEL_SLOTS_M1)) begin
        per[n] = x;
        hb += x;
        n++;
        x = div_up(x, s);
      end
      per[n] = 1;
      n++;
      hb += 1;
      used = mid + jb + hb;
      if (used <= avail && avail - used < best_pad) begin
        best_db = mid;
        best_hb = hb;
        best_pad = avail - used;
        best_lev = n;
        best_per = per;
      end
      if (used > avail) hi = mid - 1;
      else if (used < avail) lo = mid + 1;
      else break;
    end
    if (best_pad == avail) begin
      push_fault(ST_NOFIT);
      return;
    end
    if (best_lev > MAX_LEVELS) begin
      push_fault(ST_DEEP);
      return;
    end
    for (int k = 0; k < best_lev; k++) begin
      r.lvl = k[IDX_W-1:0];
      r.lvl_blocks = best_per[k][TOTAL_W-1:0];
      r.data = best_db[TOTAL_W-1:0];
      r.hash = best_hb[TOTAL_W-1:0];
      r.jb = jb;
      r.pad = best_pad[TOTAL_W-1:0];
      r.lcnt = best_lev[LCNT_W-1:0];
      r.st = ST_OK;
      r.last = (k == best_lev - 1);
      layout_q.push_back(r);
    end
  endfunction

  function automatic void cmp(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  function automatic void add_row(input logic [SHIFT_W-1:0] shift,
                                  input logic [TOTAL_W-1:0] total,
                                  input logic [JB_W-1:0] jb,
                                  input logic typed, input logic [ST_W-1:0] st);
    layout_req_t q;
    q.shift = shift;
    q.total = total;
    q.jb = jb;
    q.typed = typed;
    q.st = st;
    dir_rows.push_back(q);
  endfunction

  function automatic logic [TOTAL_W-1:0] rand_total();
    logic [63:0] v;
    int w;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return TOTAL_W'($urandom_range(12));
      1, 2: return TOTAL_W'($urandom_range(5000));
      3, 4: begin
        w = $urandom_range(48, 1);
        return TOTAL_W'(v & ((64'd1 << w) - 64'd1));
      end
      5: return v[TOTAL_W-1:0];
      6: return {TOTAL_W{1'b1}} - TOTAL_W'($urandom_range(3));
      default: return (TOTAL_W'(1) << $urandom_range(47, 3)) + TOTAL_W'($urandom_range(2)) - 1;
    endcase
  endfunction

  function automatic logic [JB_W-1:0] rand_journal(input logic [TOTAL_W-1:0] total);
    logic [TOTAL_W-1:0] t;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: t = total >> $urandom_range(40, 1);
      6, 7: t = TOTAL_W'($urandom);
      8: t = '0;
      default: t = total - TOTAL_W'($urandom_range(8));  // tight fit or no fit
    endcase
    return t[JB_W-1:0];
  endfunction

  task automatic set_shift(input logic [SHIFT_W-1:0] v);
    in_valid <= 1'b0;
    while (layout_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    shift_cfg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_layout(input logic [TOTAL_W-1:0] total, input logic [JB_W-1:0] jb,
                             input logic typed, input logic [ST_W-1:0] st);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_total_blocks <= total;
    in_journal_count <= jb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) push_fault(st);
    else plan_layout(total, jb);
    items_in++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_chk
    layout_rec_t r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (layout_q.size() == 0) begin
        $error("unexpected result transaction, level_index 0x%0h", out_level_index);
        err_count++;
      end else begin
        r = layout_q.pop_front();
        cmp("level_index", r.lvl, out_level_index);
        cmp("level_blocks", r.lvl_blocks, out_level_blocks);
        cmp("data_count", r.data, out_data_count);
        cmp("hash_count", r.hash, out_hash_count);
        cmp("journal_used", r.jb, out_journal_used);
        cmp("pad_count", r.pad, out_pad_count);
        cmp("level_count", r.lcnt, out_level_count);
        cmp("status", r.st, out_status);
        cmp("last", r.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results pending", WATCHDOG_LIMIT,
               layout_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input side.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_in >= 30) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= (!quiet && $urandom_range(99) < 10);
    end
  end

  initial begin
    logic [SHIFT_W-1:0] phase_shift[8];
    logic [TOTAL_W-1:0] t;
    layout_req_t q;
    phase_shift = '{4'd1, 4'd0, 4'd12, 4'd15, 4'd3, 4'd7, 4'd2, 4'd10};

    // shift, total_blocks, journal_count, typed, status
    add_row(4'd7, 48'd0, 32'd0, 1'b1, ST_SMALL);
    add_row(4'd7, 48'd5, 32'd0, 1'b1, ST_SMALL);
    add_row(4'd7, 48'd5, 32'hFFFF_FFFF, 1'b1, ST_SMALL);
    add_row(4'd7, 48'd6, 32'd0, 1'b0, ST_OK);
    add_row(4'd7, 48'd6, 32'd5, 1'b1, ST_NOFIT);
    add_row(4'd7, 48'd1000, 32'd1000, 1'b1, ST_NOFIT);
    add_row(4'd7, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0, ST_OK);
    add_row(4'd7, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_OK);
    add_row(4'd7, 48'h2_0000_0000, 32'hFFFF_FFFF, 1'b0, ST_OK);
    add_row(4'd0, 48'd1000, 32'd10, 1'b0, ST_OK);      // shift 0 behaves as 1
    add_row(4'd0, 48'h10_0000, 32'd0, 1'b1, ST_DEEP);
    add_row(4'd1, 48'h2_0000, 32'd0, 1'b0, ST_OK);     // level count at the limit
    add_row(4'd1, 48'h2_000A, 32'd3, 1'b0, ST_OK);
    add_row(4'd1, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b1, ST_DEEP);
    add_row(4'd12, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0, ST_OK);
    add_row(4'd12, 48'd4099, 32'd7, 1'b0, ST_OK);
    add_row(4'd15, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_OK);
    add_row(4'd15, 48'd6, 32'd0, 1'b0, ST_OK);
    add_row(4'd15, 48'd6, 32'd4, 1'b1, ST_NOFIT);
    add_row(4'd15, 48'd2, 32'd0, 1'b1, ST_SMALL);
    add_row(4'd7, 48'd100, 32'd3, 1'b0, ST_OK);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      q = dir_rows[i];
      if (q.shift != shift_cfg) set_shift(q.shift);
      send_layout(q.total, q.jb, q.typed, q.st);
    end

    foreach (phase_shift[p]) begin
      set_shift(phase_shift[p]);
      quiet = (p == 5);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        t = rand_total();
        send_layout(t, rand_journal(t), 1'b0, ST_OK);
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (layout_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d layout requests under %0d fanout writes; %0d level results checked.",
             items_in, cfg_writes, results_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
